[src/kci_pkg.sv]
// shared constants and types of the keyframe colour interpolator
package kci_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int TIME_BITS  = 32;
    localparam int FRAC_BITS  = 16;

    localparam int ADDR_W   = $clog2(MAX_FRAMES);
    localparam int NUM_W    = $clog2(MAX_FRAMES + 1);
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int COLOR_W  = NUM_CH * CH_W;
    localparam int SAT_SH   = 9;
    localparam int QB       = FRAC_BITS + SAT_SH;
    localparam int QCNT_W   = $clog2(QB);
    localparam int FMAG_W   = QB + 1;
    localparam int PROD_W   = CH_W + FMAG_W;
    localparam int STEP_W   = PROD_W - FRAC_BITS;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic empty;
        logic step;
        logic shift;
        logic hit;
        logic last;
        logic prep;
        logic div;
        logic mul;
        logic load_res;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero_frames;
        logic hit;
        logic last;
        logic out_free;
    } t_sts;

endpackage

[src/kci_ctrl.sv]
// sequencing controller: table scan, fraction division and blend steps
module kci_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    output logic          o_stall,
    input  kci_pkg::t_sts i_sts,
    output kci_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    t_state                      r_state, n_state;
    logic [kci_pkg::QCNT_W-1:0]  r_bit_cnt, n_bit_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_bit_cnt = r_bit_cnt;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == kci_pkg::FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (i_sts.zero_frames) begin
                        o_cmd.empty = 1'b1;
                        n_state     = S_FIN;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                o_cmd.step = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_PREP;
                end else if (i_sts.last) begin
                    o_cmd.last = 1'b1;
                    n_state    = S_MUL;
                end else begin
                    o_cmd.shift = 1'b1;
                    o_cmd.step  = 1'b1;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_bit_cnt  = kci_pkg::QCNT_W'(kci_pkg::QB - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_bit_cnt = r_bit_cnt - 1'b1;
                if (r_bit_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.load_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_bit_cnt <= n_bit_cnt;
        end
    end

endmodule

[src/kci_dp.sv]
// datapath: frame tables, scan registers, fraction divider, blend and result register
module kci_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kci_pkg::t_cmd               i_cmd,
    output kci_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [kci_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic [kci_pkg::IDX_W-1:0]   i_frame_index,
    input  logic [31:0]                 i_time_value,
    input  logic [kci_pkg::CH_W-1:0]    i_red,
    input  logic [kci_pkg::CH_W-1:0]    i_green,
    input  logic [kci_pkg::CH_W-1:0]    i_blue,
    input  logic [kci_pkg::CH_W-1:0]    i_alpha,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [kci_pkg::CH_W-1:0]    o_out_red,
    output logic [kci_pkg::CH_W-1:0]    o_out_green,
    output logic [kci_pkg::CH_W-1:0]    o_out_blue,
    output logic [kci_pkg::CH_W-1:0]    o_out_alpha,
    output logic [kci_pkg::IDX_W-1:0]   o_frame_used,
    output logic                        o_valid_res
);

    localparam int TB  = kci_pkg::TIME_BITS;
    localparam int AW  = kci_pkg::ADDR_W;
    localparam int CW  = kci_pkg::CH_W;
    localparam int NCH = kci_pkg::NUM_CH;
    localparam int NW  = TB + kci_pkg::FRAC_BITS;

    logic [TB-1:0]               time_mem  [kci_pkg::MAX_FRAMES];
    logic [kci_pkg::COLOR_W-1:0] color_mem [kci_pkg::MAX_FRAMES];

    logic [kci_pkg::CNT_W-1:0]   r_frame_count;
    logic [AW-1:0]               r_addr;
    logic [AW-1:0]               r_rd_idx;
    logic [TB-1:0]               r_rd_time;
    logic [kci_pkg::COLOR_W-1:0] r_rd_color;
    logic [TB-1:0]               r_qtime;
    logic [TB-1:0]               r_t0, r_t1;
    logic [kci_pkg::COLOR_W-1:0] r_c0, r_c1;
    logic [AW-1:0]               r_active;
    logic                        r_empty;
    logic [TB-1:0]               r_dmag;
    logic                        r_neg, r_sat, r_den_zero;
    logic [TB-1:0]               r_rem;
    logic [kci_pkg::QB-1:0]      r_low;
    logic [kci_pkg::QB-1:0]      r_quot;
    logic [kci_pkg::PROD_W-1:0]  r_prod [NCH];
    logic [NCH-1:0]              r_sgn;

    logic                        r_out_valid;
    logic [CW-1:0]               r_out_ch [NCH];
    logic [AW-1:0]               r_out_idx;
    logic                        r_out_vres;

    logic [kci_pkg::NUM_W-1:0]   n_eff;
    logic [TB-1:0]               qtime_in;
    logic [TB:0]                 num_diff, den_diff, num_neg, den_neg;
    logic [TB-1:0]               nmag, dmag;
    logic [NW-1:0]               n_wide;
    logic [TB:0]                 rem_sh;
    logic                        rem_ge;
    logic [kci_pkg::FMAG_W-1:0]  fmag;
    logic [CW-1:0]               ch0 [NCH];
    logic [CW-1:0]               dch [NCH];
    logic                        dneg [NCH];
    logic [CW-1:0]               blend [NCH];
    logic [kci_pkg::STEP_W-1:0]  step_mag [NCH];
    logic [kci_pkg::STEP_W:0]    up_sum [NCH];

    assign qtime_in = TB'(i_time_value);

    always_comb begin
        if (32'(r_frame_count) > kci_pkg::MAX_FRAMES) begin
            n_eff = kci_pkg::NUM_W'(kci_pkg::MAX_FRAMES);
        end else begin
            n_eff = kci_pkg::NUM_W'(r_frame_count);
        end
    end

    assign o_sts.zero_frames = (r_frame_count == '0);
    // the successor of the previous frame starts after the query
    assign o_sts.hit      = (r_rd_idx != '0) && (r_qtime < r_rd_time);
    assign o_sts.last     = (kci_pkg::NUM_W'(r_rd_idx) == n_eff - kci_pkg::NUM_W'(1));
    assign o_sts.out_free = !r_out_valid || !i_stall;

    // signed spans as sign and magnitude
    assign num_diff = {1'b0, r_qtime} - {1'b0, r_t0};
    assign den_diff = {1'b0, r_t1} - {1'b0, r_t0};
    assign num_neg  = ~num_diff + 1'b1;
    assign den_neg  = ~den_diff + 1'b1;
    assign nmag     = num_diff[TB] ? num_neg[TB-1:0] : num_diff[TB-1:0];
    assign dmag     = den_diff[TB] ? den_neg[TB-1:0] : den_diff[TB-1:0];
    assign n_wide   = {nmag, {kci_pkg::FRAC_BITS{1'b0}}};

    // one restoring division step a cycle
    assign rem_sh = {r_rem, r_low[kci_pkg::QB-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_dmag});

    always_comb begin
        if (r_den_zero) begin
            fmag = '0;
        end else if (r_sat) begin
            fmag = kci_pkg::FMAG_W'(1) << kci_pkg::QB;
        end else begin
            fmag = {1'b0, r_quot};
        end
    end

    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            logic [CW-1:0] c1;
            c1       = r_c1[k*CW +: CW];
            ch0[k]   = r_c0[k*CW +: CW];
            dneg[k]  = (c1 < ch0[k]);
            dch[k]   = dneg[k] ? (ch0[k] - c1) : (c1 - ch0[k]);
        end
    end

    // truncation toward zero is a shift of the magnitude
    always_comb begin
        for (int k = 0; k < NCH; k++) begin
            step_mag[k] = r_prod[k][kci_pkg::PROD_W-1:kci_pkg::FRAC_BITS];
            up_sum[k]   = {1'b0, step_mag[k]} + (kci_pkg::STEP_W + 1)'(ch0[k]);
            if (r_sgn[k]) begin
                if (step_mag[k] > kci_pkg::STEP_W'(ch0[k])) begin
                    blend[k] = '0;
                end else begin
                    blend[k] = ch0[k] - step_mag[k][CW-1:0];
                end
            end else begin
                if (up_sum[k] > (kci_pkg::STEP_W + 1)'({CW{1'b1}})) begin
                    blend[k] = '1;
                end else begin
                    blend[k] = up_sum[k][CW-1:0];
                end
            end
        end
    end

    // frame tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_frame_index) < kci_pkg::MAX_FRAMES)) begin
            time_mem[AW'(i_frame_index)]  <= qtime_in;
            color_mem[AW'(i_frame_index)] <= {i_alpha, i_blue, i_green, i_red};
        end
        r_rd_time  <= time_mem[r_addr];
        r_rd_color <= color_mem[r_addr];
        r_rd_idx   <= r_addr;
    end

    // scan, division and blend registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qtime <= qtime_in;
            r_addr  <= '0;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_cmd.shift) begin
            r_t0 <= r_rd_time;
            r_c0 <= r_rd_color;
        end
        if (i_cmd.hit) begin
            r_t1     <= r_rd_time;
            r_c1     <= r_rd_color;
            r_active <= r_rd_idx - 1'b1;
        end
        if (i_cmd.last) begin
            r_c0       <= r_rd_color;
            r_c1       <= r_rd_color;
            r_active   <= r_rd_idx;
            r_den_zero <= 1'b1;
            r_neg      <= 1'b0;
        end
        if (i_cmd.prep) begin
            r_dmag     <= dmag;
            r_neg      <= num_diff[TB] ^ den_diff[TB];
            r_den_zero <= (dmag == '0);
            r_sat      <= ({{kci_pkg::SAT_SH{1'b0}}, nmag} >=
                           {dmag, {kci_pkg::SAT_SH{1'b0}}});
            r_rem      <= TB'(n_wide >> kci_pkg::QB);
            r_low      <= n_wide[kci_pkg::QB-1:0];
            r_quot     <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= rem_ge ? TB'(rem_sh - {1'b0, r_dmag}) : rem_sh[TB-1:0];
            r_low  <= {r_low[kci_pkg::QB-2:0], 1'b0};
            r_quot <= {r_quot[kci_pkg::QB-2:0], rem_ge};
        end
        if (i_cmd.mul) begin
            for (int k = 0; k < NCH; k++) begin
                r_prod[k] <= kci_pkg::PROD_W'(dch[k]) * kci_pkg::PROD_W'(fmag);
                r_sgn[k]  <= dneg[k] ^ r_neg;
            end
        end
        if (i_cmd.load_res) begin
            for (int k = 0; k < NCH; k++) begin
                r_out_ch[k] <= r_empty ? '0 : blend[k];
            end
            r_out_idx  <= r_empty ? '0 : r_active;
            r_out_vres <= !r_empty;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
            r_empty       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
            if (i_cmd.empty) begin
                r_empty <= 1'b1;
            end else if (i_cmd.start) begin
                r_empty <= 1'b0;
            end
            if (i_cmd.load_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_red    = r_out_ch[0];
    assign o_out_green  = r_out_ch[1];
    assign o_out_blue   = r_out_ch[2];
    assign o_out_alpha  = r_out_ch[3];
    assign o_frame_used = kci_pkg::IDX_W'(r_out_idx);
    assign o_valid_res  = r_out_vres;

endmodule

[src/keyframe_color_interpolator_top.sv]
// top level of the keyframe colour interpolator
//
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+--------------------------------------
//  input    | in        | i_valid / o_stall    | func, frame_index, time_value, rgba
//  result   | out       | o_valid / i_stall    | out rgba, frame_used, valid_res
//  config   | in        | i_cfg_valid / ready  | frame_count (7 bits)
//
//  a load beat is written in the cycle it is accepted; the next beat can follow at once.
//  a query scans the frame table one entry after another until the scan stops at entry k;
//  when it blends, it then sets up the divider and takes one quotient bit a cycle; it then
//  multiplies and loads its result, and the next beat is taken only after that load.
//  the sequential frame-table scan and the bit-serial divider set how long a query takes.
//  synchronous active-low reset clears frame_count and empties the result register.
//  a stalled result holds in its register; a further query waits only at its last step.
module keyframe_color_interpolator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_func,
    input  logic [kci_pkg::IDX_W-1:0]           i_frame_index,
    input  logic [31:0]                         i_time_value,
    input  logic [kci_pkg::CH_W-1:0]            i_red,
    input  logic [kci_pkg::CH_W-1:0]            i_green,
    input  logic [kci_pkg::CH_W-1:0]            i_blue,
    input  logic [kci_pkg::CH_W-1:0]            i_alpha,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [kci_pkg::CH_W-1:0]            o_out_red,
    output logic [kci_pkg::CH_W-1:0]            o_out_green,
    output logic [kci_pkg::CH_W-1:0]            o_out_blue,
    output logic [kci_pkg::CH_W-1:0]            o_out_alpha,
    output logic [kci_pkg::IDX_W-1:0]           o_frame_used,
    output logic                                o_valid_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kci_pkg::CNT_W-1:0]           i_cfg_data
);

    kci_pkg::t_cmd cmd;
    kci_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    kci_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kci_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_frame_index (i_frame_index),
        .i_time_value  (i_time_value),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_alpha       (i_alpha),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha),
        .o_frame_used  (o_frame_used),
        .o_valid_res   (o_valid_res)
    );

endmodule

[src/kci_chk.sv]
// port checker for the keyframe colour interpolator, bound to the top level
module kci_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic                                i_func,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [kci_pkg::CH_W-1:0]            o_out_red,
    input  logic [kci_pkg::CH_W-1:0]            o_out_green,
    input  logic [kci_pkg::CH_W-1:0]            o_out_blue,
    input  logic [kci_pkg::CH_W-1:0]            o_out_alpha,
    input  logic [kci_pkg::IDX_W-1:0]           o_frame_used,
    input  logic                                o_valid_res
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_used) && $stable(o_out_red)
            && $stable(o_valid_res))
        else $error("stalled result beat changed");

    // an empty table gives an all-zero colour
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_out_red == '0 && o_out_green == '0
            && o_out_blue == '0 && o_out_alpha == '0)
        else $error("colour not zero without frames");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_frame_used == '0)
        else $error("frame index not zero without frames");

    // a query keeps the input side stalled while it is worked on
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_func == kci_pkg::FUNC_QUERY |=> o_stall)
        else $error("input not stalled after a query beat");

    // a load never stalls the next beat
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_func == kci_pkg::FUNC_LOAD |=> !o_stall)
        else $error("input stalled after a load beat");

endmodule

bind keyframe_color_interpolator_top kci_chk u_kci_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_func       (i_func),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_red    (o_out_red),
    .o_out_green  (o_out_green),
    .o_out_blue   (o_out_blue),
    .o_out_alpha  (o_out_alpha),
    .o_frame_used (o_frame_used),
    .o_valid_res  (o_valid_res)
);
